FILE: rtl/core/gra_pkg.sv
// Shared types and constants of the grid rectangle allocator.
package gra_pkg;

  localparam int unsigned COLUMNS   = 8;
  localparam int unsigned MAX_ROWS  = 15;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned SLOT_W    = COL_W + ROW_W;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned CMD_W     = 3;
  localparam logic [ROW_W-1:0] ROW_COUNT_RESET = ROW_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_PLACE_AT  = 3'd0,
    CMD_FIRST_FIT = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_QUERY     = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/gra_ctrl.sv
// Controller state machine of the grid rectangle allocator.
module gra_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [gra_pkg::CMD_W-1:0] command_i,
  input  gra_pkg::dp_stat_t        stat_i,
  output gra_pkg::dp_cmd_t         cmd_o
);
  import gra_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (cmd_e'(command_i)) inside
            CMD_FIRST_FIT, CMD_QUERY: state_d = S_SCAN;
            default:                  state_d = S_EXEC;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_SCAN || state_q == S_EXEC))
    else $error("load did not start work");

  a_commit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == S_IDLE && !in_stall_o))
    else $error("controller not free after commit");

  a_scan_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_step |-> !cmd_o.commit && in_stall_o)
    else $error("commit during scan");

endmodule

FILE: rtl/core/gra_dp.sv
// Datapath of the grid rectangle allocator: occupancy map, anchor test, result register.
module gra_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_write_i,
  input  logic [gra_pkg::ROW_W-1:0]    cfg_row_count_i,
  input  logic [gra_pkg::CMD_W-1:0]    command_i,
  input  logic [gra_pkg::SLOT_W-1:0]   slot_i,
  input  logic [gra_pkg::SIZE_W-1:0]   item_width_i,
  input  logic [gra_pkg::SIZE_W-1:0]   item_height_i,
  input  gra_pkg::dp_cmd_t             cmd_i,
  output gra_pkg::dp_stat_t            stat_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [gra_pkg::SLOT_W-1:0]   placed_slot_o
);
  import gra_pkg::*;

  logic [COLUMNS-1:0] occ_q [MAX_ROWS];
  logic [COLUMNS-1:0] occ_d [MAX_ROWS];
  logic [ROW_W-1:0]   rows_q;
  cmd_e               op_q;
  logic [SLOT_W-1:0]  anchor_q;
  logic [SIZE_W-1:0]  width_q, height_q;
  logic               found_q;
  logic               out_valid_q;
  logic               status_q;
  logic [SLOT_W-1:0]  placed_q;

  logic [COL_W-1:0]   ax;
  logic [ROW_W-1:0]   ay;
  logic [4:0]         x_end, y_end;
  logic               in_bounds, hit, fit, anchor_free, exhausted, cand;
  logic [COLUMNS-1:0] mask, anchor_row;
  logic [MAX_ROWS-1:0] row_sel;
  logic               ok, paint_set, paint_clr;
  logic [SLOT_W-1:0]  placed_d;

  assign ax    = anchor_q[COL_W-1:0];
  assign ay    = anchor_q[SLOT_W-1:COL_W];
  assign x_end = {2'b00, ax} + {1'b0, width_q};
  assign y_end = {1'b0, ay} + {1'b0, height_q};

  assign in_bounds = (ay < rows_q) && (x_end <= 5'(COLUMNS)) && (y_end <= {1'b0, rows_q});

  always_comb begin
    mask       = '0;
    row_sel    = '0;
    hit        = 1'b0;
    anchor_row = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      mask[c] = (5'(c) >= {2'b00, ax}) && (5'(c) < x_end);
    end
    for (int r = 0; r < MAX_ROWS; r++) begin
      row_sel[r] = (ROW_W'(r) >= ay) && (5'(r) < y_end);
      hit        = hit | (row_sel[r] & (|(occ_q[r] & mask)));
      if (ay == ROW_W'(r)) begin
        anchor_row = occ_q[r];
      end
    end
  end

  assign fit         = in_bounds && !hit;
  assign anchor_free = !anchor_row[ax];
  assign exhausted   = (ay >= rows_q);
  assign cand        = !exhausted && anchor_free && fit;

  assign stat_o.scan_end = exhausted || cand;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ok        = 1'b0;
    paint_set = 1'b0;
    paint_clr = 1'b0;
    placed_d  = '0;
    case (op_q)
      CMD_PLACE_AT: begin
        ok        = fit;
        paint_set = fit;
        placed_d  = fit ? anchor_q : '0;
      end
      CMD_FIRST_FIT: begin
        ok        = found_q;
        paint_set = found_q;
        placed_d  = found_q ? anchor_q : '0;
      end
      CMD_REMOVE: begin
        ok        = in_bounds;
        paint_clr = in_bounds;
      end
      CMD_QUERY: ok = found_q;
      CMD_CLEAR: ok = 1'b1;
      default:   ok = 1'b0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      occ_d[r] = occ_q[r];
      if (cmd_i.commit) begin
        if (op_q == CMD_CLEAR) begin
          occ_d[r] = '0;
        end else if (paint_set && row_sel[r]) begin
          occ_d[r] = occ_q[r] | mask;
        end else if (paint_clr && row_sel[r]) begin
          occ_d[r] = occ_q[r] & ~mask;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        occ_q[r] <= '0;
      end
      rows_q      <= ROW_COUNT_RESET;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cfg_write_i) begin
        rows_q <= cfg_row_count_i;
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_step && cand) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= cmd_e'(command_i);
      width_q  <= item_width_i;
      height_q <= item_height_i;
      case (cmd_e'(command_i)) inside
        CMD_FIRST_FIT, CMD_QUERY: anchor_q <= '0;
        default:                  anchor_q <= slot_i;
      endcase
    end else if (cmd_i.scan_step && !stat_o.scan_end) begin
      anchor_q <= anchor_q + SLOT_W'(1);
    end
    if (cmd_i.commit) begin
      status_q <= !ok;
      placed_q <= placed_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign placed_slot_o = placed_q;

  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while held");

  a_first_fit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_q == CMD_FIRST_FIT && found_q) |-> (fit && anchor_free))
    else $error("first-fit anchor no longer fits");

  a_drain_needs_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

endmodule

FILE: rtl/core/grid_rectangle_allocator.sv
// Top level of the grid rectangle allocator.
//
// Keeps an occupancy map of an 8-column grid with row_count active rows
// (reset 4, up to 15). Each input word carries a command, an anchor slot
// (row*8 + column) and a rectangle width and height; each accepted word
// yields exactly one output word with status and placed_slot.
// Input: in_valid_i / in_stall_o; a word is taken when valid is high and
// stall is low. The block takes one word at a time and stalls until its
// result has been loaded into the output register.
// Place-at, remove, clear and unknown commands go from acceptance straight to
// the commit state. First-fit and query test one anchor rectangle per cycle in
// row-major order until the first fitting anchor or the end of the active rows,
// then go to the commit state.
// Output: out_valid_o / out_stall_i; a held result stays stable while
// stalled, and a finished command waits before committing its map update
// until the output register is free.
// Configuration: cfg_valid_i / cfg_ready_o writes row_count; write only
// while no command is in flight.
// Reset clears the whole map at once and sets row_count to 4.
module grid_rectangle_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gra_pkg::ROW_W-1:0]    cfg_row_count_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gra_pkg::CMD_W-1:0]    command_i,
  input  logic [gra_pkg::SLOT_W-1:0]   slot_i,
  input  logic [gra_pkg::SIZE_W-1:0]   item_width_i,
  input  logic [gra_pkg::SIZE_W-1:0]   item_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         status_o,
  output logic [gra_pkg::SLOT_W-1:0]   placed_slot_o
);
  import gra_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  gra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  gra_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_write_i     (cfg_valid_i & cfg_ready_o),
    .cfg_row_count_i (cfg_row_count_i),
    .command_i       (command_i),
    .slot_i          (slot_i),
    .item_width_i    (item_width_i),
    .item_height_i   (item_height_i),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .placed_slot_o   (placed_slot_o)
  );

endmodule

FILE: tb/grid_rectangle_allocator_tb.sv
// Self-checking testbench for the grid rectangle allocator, directed and random commands.
module grid_rectangle_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gra_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              status;
    logic [SLOT_W-1:0] slot;
  } alloc_result_t;

  typedef struct {
    int anchor;
    int w;
    int h;
  } rect_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ROW_W-1:0]    cfg_row_count_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [SIZE_W-1:0]   item_width_i;
  logic [SIZE_W-1:0]   item_height_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                status_o;
  logic [SLOT_W-1:0]   placed_slot_o;

  logic [COLUMNS-1:0]  occ_map [MAX_ROWS];
  int                  row_cfg;
  alloc_result_t       pending_results [$];
  rect_t               placed_rects [$];
  alloc_result_t       want;

  stall_mode_e         stall_mode = STALL_NONE;
  int                  hold_request = 0;
  bit                  gaps_on = 0;
  int                  burst_left = 0;

  int                  err_count = 0;
  int                  words_sent = 0;
  int                  results_seen = 0;
  int                  fit_hits = 0;
  int                  cfg_writes = 0;

  grid_rectangle_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_row_count_i (cfg_row_count_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .slot_i          (slot_i),
    .item_width_i    (item_width_i),
    .item_height_i   (item_height_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .placed_slot_o   (placed_slot_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int active_rows();
    return (row_cfg > MAX_ROWS) ? MAX_ROWS : row_cfg;
  endfunction

  function automatic bit rect_in_grid(int x, int y, int w, int h);
    int rows;
    rows = active_rows();
    if (y >= rows) return 1'b0;
    return (x + w <= COLUMNS) && (y + h <= rows);
  endfunction

  function automatic logic [COLUMNS-1:0] col_mask(int x, int w);
    return COLUMNS'(((1 << w) - 1) << x);
  endfunction

  function automatic bit rect_free(int x, int y, int w, int h);
    logic [COLUMNS-1:0] m;
    if (!rect_in_grid(x, y, w, h)) return 1'b0;
    m = col_mask(x, w);
    for (int r = 0; r < h; r++) begin
      if ((occ_map[y + r] & m) != '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void paint_rect(int x, int y, int w, int h, bit taken);
    logic [COLUMNS-1:0] m;
    m = col_mask(x, w);
    for (int r = 0; r < h; r++) begin
      if (taken) occ_map[y + r] |= m;
      else occ_map[y + r] &= ~m;
    end
  endfunction

  function automatic bit find_anchor(int w, int h, output int ax, output int ay);
    ax = 0;
    ay = 0;
    for (int y = 0; y < active_rows(); y++) begin
      for (int x = 0; x < COLUMNS; x++) begin
        if (occ_map[y][x]) continue;
        if (rect_free(x, y, w, h)) begin
          ax = x;
          ay = y;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t apply_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                                  int w, int h);
    alloc_result_t res;
    int x;
    int y;
    res.cmd    = cmd;
    res.status = 1'b1;
    res.slot   = '0;
    x = int'(slot) % COLUMNS;
    y = int'(slot) / COLUMNS;
    case (cmd)
      CMD_PLACE_AT: begin
        if (rect_free(x, y, w, h)) begin
          paint_rect(x, y, w, h, 1'b1);
          res.status = 1'b0;
          res.slot   = slot;
          placed_rects.push_back('{int'(slot), w, h});
        end
      end
      CMD_FIRST_FIT: begin
        if (find_anchor(w, h, x, y)) begin
          paint_rect(x, y, w, h, 1'b1);
          res.status = 1'b0;
          res.slot   = SLOT_W'(y * COLUMNS + x);
          placed_rects.push_back('{y * COLUMNS + x, w, h});
          fit_hits++;
        end
      end
      CMD_REMOVE: begin
        if (rect_in_grid(x, y, w, h)) begin
          paint_rect(x, y, w, h, 1'b0);
          res.status = 1'b0;
        end
      end
      CMD_QUERY: begin
        if (find_anchor(w, h, x, y)) res.status = 1'b0;
      end
      CMD_CLEAR: begin
        foreach (occ_map[r]) occ_map[r] = '0;
        placed_rects.delete();
        res.status = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0b slot=%0d", status_o,
                                  placed_slot_o));
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (status_o !== want.status)
          report_mismatch($sformatf("cmd %0d status %0b, want %0b", want.cmd, status_o,
                                    want.status));
        if (placed_slot_o !== want.slot)
          report_mismatch($sformatf("cmd %0d placed_slot %0d, want %0d", want.cmd,
                                    placed_slot_o, want.slot));
      end
    end
  end

  initial begin
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= (tick % 4 != 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input int slot, input int w,
                           input int h);
    int gap;
    gap = 0;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    slot_i        <= SLOT_W'(slot);
    item_width_i  <= SIZE_W'(w);
    item_height_i <= SIZE_W'(h);
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_command(cmd, SLOT_W'(slot), w, h));
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_row_count(input int rows);
    cfg_valid_i     <= 1'b1;
    cfg_row_count_i <= ROW_W'(rows);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    row_cfg = rows;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic test_fill_and_scan();
    send_word(CMD_PLACE_AT, 0, 8, 4);
    send_word(CMD_FIRST_FIT, 0, 1, 1);
    send_word(CMD_QUERY, 0, 1, 1);
    send_word(CMD_REMOVE, 0, 8, 4);
    send_word(CMD_PLACE_AT, 0, 3, 1);
    send_word(CMD_FIRST_FIT, 0, 2, 2);
    send_word(CMD_REMOVE, 9, 2, 2);
    send_word(CMD_CLEAR, 0, 1, 1);
  endtask

  task automatic test_bounds();
    send_word(CMD_PLACE_AT, 7, 2, 1);
    send_word(CMD_PLACE_AT, 24, 1, 2);
    send_word(CMD_PLACE_AT, 127, 0, 0);
    send_word(CMD_REMOVE, 32, 0, 0);
    send_word(CMD_FIRST_FIT, 0, 15, 15);
  endtask

  task automatic test_empty_rect();
    send_word(CMD_PLACE_AT, 5, 0, 3);
    send_word(CMD_FIRST_FIT, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_REMOVE, 31, 0, 0);
  endtask

  task automatic test_unknown_cmd();
    send_word(CMD_RSVD5, 0, 1, 1);
    send_word(CMD_RSVD6, 64, 8, 15);
    send_word(CMD_RSVD7, 127, 15, 15);
  endtask

  task automatic test_row_count_limits();
    wait_for_results();
    write_row_count(0);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_PLACE_AT, 0, 0, 0);
    send_word(CMD_REMOVE, 0, 1, 1);
    wait_for_results();
    write_row_count(15);
    send_word(CMD_PLACE_AT, 112, 8, 1);
    send_word(CMD_FIRST_FIT, 0, 8, 15);
    wait_for_results();
    write_row_count(1);
    send_word(CMD_FIRST_FIT, 0, 8, 1);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    stall_mode = STALL_NONE;
    gaps_on = 0;
    write_row_count(4);
    hold_request = 250;
    repeat (12) send_word(CMD_FIRST_FIT, 0, $urandom_range(1, 4), $urandom_range(1, 2));
    wait_for_results();
  endtask

  task automatic send_random_word();
    int pick;
    int rows;
    int idx;
    rect_t rect;
    pick = $urandom_range(0, 99);
    rows = (active_rows() > 0) ? active_rows() : 1;
    if (pick < 12) begin
      send_word(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom_range(0, 15),
                $urandom_range(0, 15));
    end else if (pick < 42) begin
      send_word(CMD_FIRST_FIT, $urandom_range(0, 127), $urandom_range(1, $urandom_range(1, 8)),
                $urandom_range(1, $urandom_range(1, rows)));
    end else if (pick < 64) begin
      send_word(CMD_PLACE_AT, $urandom_range(0, rows * COLUMNS - 1),
                $urandom_range(1, $urandom_range(1, 8)),
                $urandom_range(1, $urandom_range(1, rows)));
    end else if (pick < 84) begin
      if (placed_rects.size() != 0) begin
        idx = $urandom_range(0, placed_rects.size() - 1);
        rect = placed_rects[idx];
        placed_rects.delete(idx);
        send_word(CMD_REMOVE, rect.anchor, rect.w, rect.h);
      end else begin
        send_word(CMD_REMOVE, $urandom_range(0, rows * COLUMNS - 1), $urandom_range(1, 8),
                  $urandom_range(1, rows));
      end
    end else if (pick < 97) begin
      send_word(CMD_QUERY, $urandom_range(0, 127), $urandom_range(1, 8),
                $urandom_range(1, rows));
    end else begin
      send_word(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 15),
                $urandom_range(0, 15));
    end
  endtask

  task automatic test_random_traffic();
    int phase_rows [8];
    phase_rows = '{4, 15, 1, 8, 3, 15, 0, 6};
    phase_rows[6] = $urandom_range(1, 15);
    for (int p = 0; p < 8; p++) begin
      wait_for_results();
      write_row_count(phase_rows[p]);
      stall_mode = (p == 0) ? STALL_NONE : stall_mode_e'($urandom_range(0, 3));
      gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      burst_left = 0;
      repeat (240) send_random_word();
    end
  endtask

  task automatic finish_run();
    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Covered %0d commands, %0d results checked, %0d first-fit placements,",
             words_sent, results_seen, fit_hits);
    $display("over %0d row-count writes with bursty input and output stalls; %0d errors",
             cfg_writes, err_count);
    if (err_count == 0) begin
      $display("grid_rectangle_allocator: match");
    end else begin
      $display("grid_rectangle_allocator: mismatch");
    end
    $finish;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_row_count_i <= ROW_COUNT_RESET;
    in_valid_i      <= 1'b0;
    command_i       <= '0;
    slot_i          <= '0;
    item_width_i    <= '0;
    item_height_i   <= '0;
    row_cfg = int'(ROW_COUNT_RESET);
    foreach (occ_map[r]) occ_map[r] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_mode = STALL_LIGHT;
    gaps_on = 1;
    test_fill_and_scan();
    test_bounds();
    test_empty_rect();
    test_unknown_cmd();
    test_row_count_limits();
    test_output_backpressure();
    test_random_traffic();
    finish_run();
  end

  initial begin
    #50ms;
    $display("grid_rectangle_allocator: mismatch");
    $finish;
  end

endmodule
